[rtl/aes_ctr_pkg.sv]
// Shared types, constants and byte-level functions of the AES-128 / CTR core.
package aes_ctr_pkg;

   localparam int BlockWidth = 128;
   localparam int HalfWidth  = 64;
   localparam int NumRounds  = 10;
   localparam int MaxRunDefault = 64;
   localparam int CountWidth = 7;

   localparam logic [1:0] KIND_ENC = 2'd0;
   localparam logic [1:0] KIND_DEC = 2'd1;
   localparam logic [1:0] KIND_CTR = 2'd2;

   localparam logic [0:0] REG_KEY_HIGH = 1'b0;
   localparam logic [0:0] REG_KEY_LOW  = 1'b1;

   typedef logic [BlockWidth-1:0] block_type;
   typedef logic [7:0] byte_type;

   // Round operation selection handed to the round unit.
   typedef struct packed {
      logic inverse;   // decrypt direction
      logic do_mix;    // apply (Inv)MixColumns
      logic do_sub;    // apply (Inv)SubBytes/ShiftRows; clear for the initial key add
   } round_ctl_type;

   function automatic byte_type xt(input byte_type a);
      xt = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
   endfunction

   function automatic byte_type gmul(input byte_type a, input byte_type b);
      byte_type p;
      byte_type t;
      p = 8'h00;
      t = a;
      for (int k = 0; k < 4; k++) begin
         if (b[k]) p = p ^ t;
         t = xt(t);
      end
      gmul = p;
   endfunction

   function automatic byte_type sbox(input byte_type x);
      byte_type s [256] = '{
         8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
         8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
         8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
         8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
         8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
         8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
         8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
         8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
         8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
         8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
         8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
         8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
         8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
         8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
         8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
         8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
      sbox = s[x];
   endfunction

   function automatic byte_type inv_sbox(input byte_type x);
      byte_type s [256] = '{
         8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
         8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
         8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
         8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
         8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
         8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
         8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
         8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
         8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
         8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
         8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
         8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
         8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
         8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
         8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
         8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d};
      inv_sbox = s[x];
   endfunction

   function automatic byte_type rcon(input logic [3:0] idx);
      case (idx)
         4'd0: rcon = 8'h01;
         4'd1: rcon = 8'h02;
         4'd2: rcon = 8'h04;
         4'd3: rcon = 8'h08;
         4'd4: rcon = 8'h10;
         4'd5: rcon = 8'h20;
         4'd6: rcon = 8'h40;
         4'd7: rcon = 8'h80;
         4'd8: rcon = 8'h1b;
         4'd9: rcon = 8'h36;
         default: rcon = 8'h00;
      endcase
   endfunction

   // Byte k of a block, byte 0 most significant.
   function automatic byte_type blk_byte(input block_type b, input int k);
      blk_byte = b[BlockWidth-1-8*k -: 8];
   endfunction

   function automatic block_type mix_block(input block_type s, input logic inverse);
      block_type o;
      byte_type a0, a1, a2, a3;
      o = '0;
      for (int c = 0; c < 4; c++) begin
         a0 = blk_byte(s, 4*c);
         a1 = blk_byte(s, 4*c+1);
         a2 = blk_byte(s, 4*c+2);
         a3 = blk_byte(s, 4*c+3);
         if (!inverse) begin
            o[BlockWidth-1-8*(4*c)   -: 8] = gmul(a0,8'd2)^gmul(a1,8'd3)^a2^a3;
            o[BlockWidth-1-8*(4*c+1) -: 8] = a0^gmul(a1,8'd2)^gmul(a2,8'd3)^a3;
            o[BlockWidth-1-8*(4*c+2) -: 8] = a0^a1^gmul(a2,8'd2)^gmul(a3,8'd3);
            o[BlockWidth-1-8*(4*c+3) -: 8] = gmul(a0,8'd3)^a1^a2^gmul(a3,8'd2);
         end else begin
            o[BlockWidth-1-8*(4*c)   -: 8] =
               gmul(a0,8'd14)^gmul(a1,8'd11)^gmul(a2,8'd13)^gmul(a3,8'd9);
            o[BlockWidth-1-8*(4*c+1) -: 8] =
               gmul(a0,8'd9)^gmul(a1,8'd14)^gmul(a2,8'd11)^gmul(a3,8'd13);
            o[BlockWidth-1-8*(4*c+2) -: 8] =
               gmul(a0,8'd13)^gmul(a1,8'd9)^gmul(a2,8'd14)^gmul(a3,8'd11);
            o[BlockWidth-1-8*(4*c+3) -: 8] =
               gmul(a0,8'd11)^gmul(a1,8'd13)^gmul(a2,8'd9)^gmul(a3,8'd14);
         end
      end
      mix_block = o;
   endfunction

endpackage

[rtl/aes_ctr_if.sv]
// Valid/ready channel interfaces for request, response and register write words.
interface aes_ctr_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  kind;
   logic [63:0] data_high;
   logic [63:0] data_low;
   logic [6:0]  block_count;
   modport source (output valid, kind, data_high, data_low, block_count, input ready);
   modport sink   (input valid, kind, data_high, data_low, block_count, output ready);
endinterface

interface aes_ctr_rsp_if;
   logic        valid;
   logic        ready;
   logic [63:0] result_high;
   logic [63:0] result_low;
   logic [63:0] next_count_high;
   logic [63:0] next_count_low;
   logic        last;
   modport source (output valid, result_high, result_low, next_count_high,
                   next_count_low, last, input ready);
   modport sink   (input valid, result_high, result_low, next_count_high,
                   next_count_low, last, output ready);
endinterface

interface aes_ctr_csr_if;
   logic        valid;
   logic        ready;
   logic [0:0]  index;
   logic [63:0] wdata;
   modport source (output valid, index, wdata, input ready);
   modport sink   (input valid, index, wdata, output ready);
endinterface

[rtl/aes128_block_and_ctr_keystream_core.sv]
// Top level of the AES-128 block and CTR keystream core.
// Each block runs the initial key add plus ten rounds in one shared round unit, and is then
// handed to the output register.
// A CTR run of N blocks (N capped at MAX_RUN) delivers N words; a lone encrypt or decrypt
// holds off the next accept, since a new word waits for the output drain.
// A key write blocks requests: latch the half, load the schedule, expand ten round keys.
// Reset (synchronous, active high) loads the all-zero key and expands it; no word is taken
// until that expansion is done.
module aes128_block_and_ctr_keystream_core
   import aes_ctr_pkg::*;
#(
   parameter int MAX_RUN = MaxRunDefault
)(
   input logic clock,
   input logic reset,
   aes_ctr_req_if.sink   req,
   aes_ctr_rsp_if.source rsp,
   aes_ctr_csr_if.sink   csr
);

   // Sequencer states.
   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_ROUND = 2'd1;
   localparam logic [1:0] ST_OUT   = 2'd2;

   logic [1:0]  state_ff, state_in;
   logic [3:0]  round_ff, round_in;
   logic        inv_ff, inv_in;
   logic        ctr_ff, ctr_in;
   logic [6:0]  left_ff, left_in;
   block_type   blk_ff, blk_in;
   block_type   cnt_ff, cnt_in;
   logic [63:0] key_hi_ff, key_lo_ff;
   logic        kstart;
   logic        kstart_d_ff;
   logic        kbusy;
   block_type   fwd_key, inv_key, rkey, rout;
   logic [3:0]  kidx;
   round_ctl_type ctl;
   logic [6:0]  count_sat;
   block_type   cnt_next;

   // Output register.
   logic        rv_ff;
   logic [63:0] r_hi_ff, r_lo_ff, n_hi_ff, n_lo_ff;
   logic        r_last_ff;

   aes_ctr_key_sched u_key (
      .clock(clock), .reset(reset), .start(kstart_d_ff),
      .cipher_key({key_hi_ff, key_lo_ff}), .rd_index(kidx),
      .fwd_key(fwd_key), .inv_key(inv_key), .busy(kbusy)
   );

   // Decrypt walks the schedule from the top down.
   assign kidx = inv_ff ? 4'(NumRounds) - round_ff : round_ff;
   assign rkey = inv_ff ? inv_key : fwd_key;

   always_comb begin
      ctl.inverse = inv_ff;
      ctl.do_sub  = (round_ff != 4'd0);
      ctl.do_mix  = (round_ff != 4'd0) && (round_ff != 4'(NumRounds));
   end

   aes_ctr_round u_round (.state_in(blk_ff), .round_key(rkey), .ctl(ctl), .state_out(rout));

   assign csr.ready = (state_ff == ST_IDLE);
   assign kstart    = csr.valid && csr.ready;
   assign req.ready = (state_ff == ST_IDLE) && !kbusy && !kstart && !kstart_d_ff && !rv_ff;
   assign count_sat = (req.block_count > 7'(MAX_RUN)) ? 7'(MAX_RUN) : req.block_count;
   assign cnt_next  = cnt_ff + 128'd1;

   always_ff @(posedge clock) begin
      if (reset) begin
         key_hi_ff <= '0;
         key_lo_ff <= '0;
      end else if (kstart) begin
         // Apply the new half now; expansion starts next cycle.
         if (csr.index == REG_KEY_HIGH) key_hi_ff <= csr.wdata;
         else key_lo_ff <= csr.wdata;
      end
   end

   // Register the expansion start so it sees the written half.
   always_ff @(posedge clock) begin
      if (reset) kstart_d_ff <= 1'b0;
      else kstart_d_ff <= kstart;
   end

   always_comb begin
      state_in = state_ff;
      round_in = round_ff;
      inv_in   = inv_ff;
      ctr_in   = ctr_ff;
      left_in  = left_ff;
      blk_in   = blk_ff;
      cnt_in   = cnt_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req.valid && req.ready) begin
               // Load the block; unused kinds and empty runs are dropped.
               blk_in   = {req.data_high, req.data_low};
               cnt_in   = {req.data_high, req.data_low};
               round_in = 4'd0;
               inv_in   = (req.kind == KIND_DEC);
               ctr_in   = (req.kind == KIND_CTR);
               left_in  = count_sat;
               if (req.kind == KIND_ENC || req.kind == KIND_DEC ||
                   (req.kind == KIND_CTR && count_sat != 7'd0))
                  state_in = ST_ROUND;
            end
         end
         ST_ROUND: begin
            blk_in = rout;
            if (round_ff == 4'(NumRounds)) state_in = ST_OUT;
            else round_in = round_ff + 4'd1;
         end
         ST_OUT: begin
            // Wait for the output register to free, then hand over the word.
            if (!rv_ff || rsp.ready) begin
               round_in = 4'd0;
               if (ctr_ff) begin
                  cnt_in  = cnt_next;
                  left_in = left_ff - 7'd1;
                  blk_in  = cnt_next;
                  state_in = (left_ff == 7'd1) ? ST_IDLE : ST_ROUND;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rv_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == ST_OUT && (!rv_ff || rsp.ready)) rv_ff <= 1'b1;
         else if (rsp.ready) rv_ff <= 1'b0;
      end
      round_ff <= round_in;
      inv_ff   <= inv_in;
      ctr_ff   <= ctr_in;
      left_ff  <= left_in;
      blk_ff   <= blk_in;
      cnt_ff   <= cnt_in;
      if (state_ff == ST_OUT && (!rv_ff || rsp.ready)) begin
         r_hi_ff   <= blk_ff[127:64];
         r_lo_ff   <= blk_ff[63:0];
         r_last_ff <= !ctr_ff || (left_ff == 7'd1);
         n_hi_ff   <= (ctr_ff && left_ff == 7'd1) ? cnt_next[127:64] : 64'd0;
         n_lo_ff   <= (ctr_ff && left_ff == 7'd1) ? cnt_next[63:0] : 64'd0;
      end
   end

   assign rsp.valid           = rv_ff;
   assign rsp.result_high     = r_hi_ff;
   assign rsp.result_low      = r_lo_ff;
   assign rsp.next_count_high = n_hi_ff;
   assign rsp.next_count_low  = n_lo_ff;
   assign rsp.last            = r_last_ff;

endmodule

[rtl/aes_ctr_round.sv]
// Shared AES round datapath: (Inv)SubBytes/ShiftRows, (Inv)MixColumns, AddRoundKey.
module aes_ctr_round
   import aes_ctr_pkg::*;
(
   input  block_type     state_in,
   input  block_type     round_key,
   input  round_ctl_type ctl,
   output block_type     state_out
);

   block_type subbed;
   block_type mixed;

   always_comb begin
      subbed = '0;
      for (int c = 0; c < 4; c++) begin
         for (int r = 0; r < 4; r++) begin
            if (!ctl.inverse)
               subbed[BlockWidth-1-8*(r+4*c) -: 8] =
                  sbox(blk_byte(state_in, r + 4*((c+r) & 3)));
            else
               subbed[BlockWidth-1-8*(r+4*((c+r) & 3)) -: 8] =
                  inv_sbox(blk_byte(state_in, r + 4*c));
         end
      end
      if (!ctl.do_sub) subbed = state_in;
      mixed = ctl.do_mix ? mix_block(subbed, ctl.inverse) : subbed;
   end

   assign state_out = mixed ^ round_key;

endmodule

[rtl/aes_ctr_key_sched.sv]
// Round-key expansion, one round key per cycle, with forward and inverse key registers.
module aes_ctr_key_sched
   import aes_ctr_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   input  block_type  cipher_key,
   input  logic [3:0] rd_index,
   output block_type  fwd_key,
   output block_type  inv_key,
   output logic       busy
);

   block_type  fwd_ff [NumRounds+1];
   block_type  inv_ff [NumRounds+1];
   logic [3:0] step_ff, step_in;
   logic       busy_ff, busy_in;
   logic [31:0] w3, t;
   block_type  prev, next_key;

   always_comb begin
      prev = fwd_ff[step_ff - 4'd1];
      w3   = prev[31:0];
      t    = {sbox(w3[23:16]), sbox(w3[15:8]), sbox(w3[7:0]), sbox(w3[31:24])};
      t[31:24] = t[31:24] ^ rcon(step_ff - 4'd1);
      next_key[127:96] = prev[127:96] ^ t;
      next_key[95:64]  = prev[95:64] ^ next_key[127:96];
      next_key[63:32]  = prev[63:32] ^ next_key[95:64];
      next_key[31:0]   = prev[31:0] ^ next_key[63:32];
      busy_in = busy_ff;
      step_in = step_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = 4'd1;
      end else if (busy_ff) begin
         if (step_ff == 4'(NumRounds)) busy_in = 1'b0;
         else step_in = step_ff + 4'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b1;
         step_ff <= 4'd1;
      end else begin
         busy_ff <= busy_in;
         step_ff <= step_in;
      end
      if (reset) begin
         fwd_ff[0] <= '0;
      end else if (start) begin
         fwd_ff[0] <= cipher_key;
      end else if (busy_ff) begin
         fwd_ff[step_ff] <= next_key;
         inv_ff[step_ff] <= mix_block(next_key, 1'b1);
      end
   end

   assign fwd_key = fwd_ff[rd_index];
   // Rounds 0 and 10 use the plain key in both directions.
   assign inv_key = (rd_index == 4'd0 || rd_index == 4'(NumRounds)) ?
                    fwd_ff[rd_index] : inv_ff[rd_index];
   assign busy = busy_ff;

endmodule
